### src/ple_pkg.sv
// Shared types and codes for the positional list engine.
// Action and status codes, field widths and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

	localparam int ACTION_W = 3;
	localparam int POS_W    = 5;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 5;

	localparam logic [ACTION_W-1:0] ACT_INS_HEAD = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INS_TAIL = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_INS_AT   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DEL_AT   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DUMP     = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MOVE = 4'b0010,
		ST_PUT  = 4'b0100,
		ST_DUMP = 4'b1000
	} state_t;

endpackage

### src/ple_ram.sv
// Entry store of the positional list engine: one write port, one read port.
// Registered read data, updated in the cycle after a read is requested. Uses ple_pkg for data width.
`timescale 1ns / 1ps

module ple_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic signed [ple_pkg::DATA_W-1:0] wdata,
	input  logic                            re,
	input  logic [AW-1:0]                   raddr,
	output logic signed [ple_pkg::DATA_W-1:0] rdata
);
	import ple_pkg::*;

	logic signed [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/positional_list_engine_top.sv
// Top level of the positional list engine: ordered list of signed values.
// Instantiates ple_ram for the entries; uses ple_pkg for codes and types.
`timescale 1ns / 1ps
//
// Usage
//   Input channel in_valid/in_stall carries action, position and value.
//   Output channel out_valid/out_stall carries status, entry_value, length
//   and last. A beat moves when valid is high and stall is low.
//   Insert and delete give one status beat, presented the cycle after the
//   input beat. The list update then shifts entries through the two-port
//   store, one entry a cycle; the next input is taken only once the update
//   is done, while a rejected insert or delete starts no update.
//   Dump gives one beat per entry, head to tail, one a cycle when the
//   receiver does not stall. An empty dump gives one beat with status
//   empty. Unused action codes are taken and dropped.
//   A stalled output holds its beat; a dump waits with it, and no new
//   input is taken while an update or dump is in flight or a beat waits.
//   Reset empties the list; the store contents need no clearing.
//   The length field is the entry count after the action, modulo 32.

module positional_list_engine_top #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ple_pkg::ACTION_W-1:0]        action,
	input  logic [ple_pkg::POS_W-1:0]           position,
	input  logic signed [ple_pkg::DATA_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ple_pkg::STATUS_W-1:0]        status,
	output logic signed [ple_pkg::DATA_W-1:0]   entry_value,
	output logic [ple_pkg::LEN_W-1:0]           length,
	output logic                                last
);
	import ple_pkg::*;

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = CW + POS_W + 1;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    moves_q;
	logic [AW-1:0]    rd_ptr_q;
	logic             ins_q;
	logic [AW-1:0]    ins_idx_q;
	logic signed [DATA_W-1:0] ins_val_q;
	logic             mv_s1;
	logic [AW-1:0]    mv_addr_s1;
	logic [CW-1:0]    dptr_q;
	logic [CW-1:0]    cons_q;
	logic             pend_q;

	logic             out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic signed [DATA_W-1:0] entry_value_q;
	logic [LEN_W-1:0] length_q;
	logic             last_q;

	logic             out_free;
	logic             in_acc;
	logic             full_c;
	logic [CMPW-1:0]  pos_w;
	logic [CMPW-1:0]  cnt_w;
	logic [CMPW-1:0]  idx_w;
	logic             do_ins;
	logic             do_del;
	logic             do_dump;
	logic             emit_c;
	logic [STATUS_W-1:0] st_c;
	logic [CW-1:0]    count_c;

	logic             re;
	logic [AW-1:0]    raddr;
	logic signed [DATA_W-1:0] rdata;
	logic             we;
	logic [AW-1:0]    waddr;
	logic signed [DATA_W-1:0] wdata;

	logic             issue;
	logic             consume;
	logic             load_dump;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	assign full_c = count_q >= CW'(CAPACITY);
	assign pos_w  = CMPW'(position);
	assign cnt_w  = CMPW'(count_q);

	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		do_dump = 1'b0;
		emit_c  = 1'b0;
		st_c    = STAT_OK;
		idx_w   = '0;
		count_c = count_q;
		unique case (action) inside
			ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
				emit_c = 1'b1;
				if (action == ACT_INS_TAIL) begin
					idx_w = cnt_w;
				end else if (action == ACT_INS_AT) begin
					idx_w = pos_w - CMPW'(1);
				end
				if (full_c) begin
					st_c = STAT_FULL;
				end else if (action == ACT_INS_AT &&
						(pos_w == '0 || pos_w > cnt_w + CMPW'(1))) begin
					st_c = STAT_BADPOS;
				end else begin
					do_ins  = 1'b1;
					count_c = count_q + CW'(1);
				end
			end
			ACT_DEL_AT: begin
				emit_c = 1'b1;
				idx_w  = pos_w - CMPW'(1);
				if (pos_w == '0 || pos_w > cnt_w) begin
					st_c = STAT_BADPOS;
				end else begin
					do_del  = 1'b1;
					count_c = count_q - CW'(1);
				end
			end
			ACT_DUMP: begin
				if (count_q == '0) begin
					emit_c = 1'b1;
					st_c   = STAT_EMPTY;
				end else begin
					do_dump = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign consume   = (state_q == ST_DUMP) && pend_q && out_free;
	assign issue     = (state_q == ST_DUMP) && (dptr_q != count_q) && (!pend_q || consume);
	assign load_dump = consume;

	always_comb begin
		re    = 1'b0;
		raddr = rd_ptr_q;
		if (state_q == ST_MOVE && moves_q != '0) begin
			re = 1'b1;
		end else if (issue) begin
			re    = 1'b1;
			raddr = dptr_q[AW-1:0];
		end
	end

	always_comb begin
		we    = mv_s1 || (state_q == ST_PUT);
		waddr = mv_s1 ? mv_addr_s1 : ins_idx_q;
		wdata = mv_s1 ? rdata : ins_val_q;
	end

	ple_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			mv_s1       <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (in_acc || load_dump) begin
				out_valid_q <= (in_acc && emit_c) || load_dump;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					mv_s1 <= 1'b0;
					if (in_acc) begin
						count_q <= count_c;
						if (do_ins || do_del) begin
							state_q <= ST_MOVE;
						end else if (do_dump) begin
							state_q <= ST_DUMP;
							pend_q  <= 1'b0;
						end
					end
				end
				ST_MOVE: begin
					mv_s1 <= moves_q != '0;
					if (moves_q == '0) begin
						state_q <= ins_q ? ST_PUT : ST_IDLE;
					end
				end
				ST_PUT: begin
					mv_s1   <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_DUMP: begin
					mv_s1 <= 1'b0;
					if (issue) begin
						pend_q <= 1'b1;
					end else if (consume) begin
						pend_q <= 1'b0;
					end
					if (dptr_q == count_q && (!pend_q || consume)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ins_q     <= do_ins;
			ins_idx_q <= idx_w[AW-1:0];
			ins_val_q <= value;
			dptr_q    <= '0;
			cons_q    <= '0;
			if (do_ins) begin
				moves_q  <= CW'(cnt_w - idx_w);
				rd_ptr_q <= AW'(cnt_w - CMPW'(1));
			end else begin
				moves_q  <= CW'(cnt_w - CMPW'(1) - idx_w);
				rd_ptr_q <= AW'(idx_w + CMPW'(1));
			end
			status_q      <= st_c;
			entry_value_q <= '0;
			length_q      <= LEN_W'(count_c);
			last_q        <= 1'b1;
		end else begin
			if (state_q == ST_MOVE && moves_q != '0) begin
				moves_q    <= moves_q - CW'(1);
				rd_ptr_q   <= ins_q ? rd_ptr_q - AW'(1) : rd_ptr_q + AW'(1);
				mv_addr_s1 <= ins_q ? rd_ptr_q + AW'(1) : rd_ptr_q - AW'(1);
			end
			if (issue) begin
				dptr_q <= dptr_q + CW'(1);
			end
			if (load_dump) begin
				cons_q        <= cons_q + CW'(1);
				status_q      <= STAT_OK;
				entry_value_q <= rdata;
				length_q      <= LEN_W'(count_q);
				last_q        <= (cons_q + CW'(1)) == count_q;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_value = entry_value_q;
	assign length      = length_q;
	assign last        = last_q;

endmodule

### verif/tb_positional_list_engine_top.sv
// Self-checking testbench for positional_list_engine_top, using ple_pkg and engine RTL.
// Drives list actions through the valid/stall input channel and checks every output beat
// against a queue-based list predictor, or against the expected beat of a directed row.
`timescale 1ns / 1ps

module tb_positional_list_engine_top;
	import ple_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 40;
	localparam int RANDOM_ITEMS = 230;

	localparam logic [ACTION_W-1:0] ACT_SPARE5 = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE6 = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE7 = 3'd7;

	typedef struct {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] entry_value;
		logic [LEN_W-1:0]         length;
		logic                     last;
	} list_beat_t;

	typedef struct {
		logic [ACTION_W-1:0]      act;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
		bit                       typed;
		logic [STATUS_W-1:0]      t_status;
		logic [LEN_W-1:0]         t_length;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [ACTION_W-1:0]      action;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_stall;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] entry_value;
	logic [LEN_W-1:0]         length;
	logic                     last;

	logic signed [DATA_W-1:0] shadow_list[$];
	list_beat_t               step_beats[$];
	list_beat_t               due_beats[$];
	stim_row_t                dir_rows[$];
	list_beat_t               got_beat;
	list_beat_t               want_beat;
	int                       mismatches = 0;
	int                       items_sent = 0;
	int                       beats_taken = 0;
	int                       cycle_count = 0;

	positional_list_engine_top #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_value(entry_value),
		.length(length),
		.last(last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TIMEOUT after %0d cycles", cycle_count);
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int pick_wait(input int n);
		if ((n / 20) % 5 == 4)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 32'sh7FFF_FFFF;
		1: return 32'sh8000_0000;
		2: return '0;
		3: return -32'sd1;
		default: return $urandom;
		endcase
	endfunction

	// Apply one action to the shadow list and collect the beats it produces.
	function automatic void list_apply(input logic [ACTION_W-1:0] act,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		int n;
		list_beat_t b;
		n = shadow_list.size();
		step_beats.delete();
		b.status = STAT_OK;
		b.entry_value = '0;
		b.last = 1'b1;
		b.length = LEN_W'(n);
		case (act)
		ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT: begin
			if (n >= CAPACITY)
				b.status = STAT_FULL;
			else if (act == ACT_INS_HEAD)
				shadow_list.push_front(val);
			else if (act == ACT_INS_TAIL)
				shadow_list.push_back(val);
			else if (pos == 0 || int'(pos) > n + 1)
				b.status = STAT_BADPOS;
			else
				shadow_list.insert(int'(pos) - 1, val);
			b.length = LEN_W'(shadow_list.size());
			step_beats.push_back(b);
		end
		ACT_DEL_AT: begin
			if (pos == 0 || int'(pos) > n)
				b.status = STAT_BADPOS;
			else
				shadow_list.delete(int'(pos) - 1);
			b.length = LEN_W'(shadow_list.size());
			step_beats.push_back(b);
		end
		ACT_DUMP: begin
			if (n == 0) begin
				b.status = STAT_EMPTY;
				step_beats.push_back(b);
			end else begin
				for (int i = 0; i < n; i++) begin
					b.entry_value = shadow_list[i];
					b.last = (i == n - 1);
					step_beats.push_back(b);
				end
			end
		end
		default: ;
		endcase
	endfunction

	function automatic stim_row_t row_of(input logic [ACTION_W-1:0] act,
			input int pos, input logic signed [DATA_W-1:0] val);
		stim_row_t r;
		r.act = act;
		r.pos = POS_W'(pos);
		r.val = val;
		r.typed = 1'b0;
		r.t_status = STAT_OK;
		r.t_length = '0;
		return r;
	endfunction

	function automatic int pick_position(input bit for_insert);
		int n;
		n = shadow_list.size();
		if ($urandom_range(0, 99) < 15)
			return $urandom_range(0, 31);
		if (for_insert)
			return $urandom_range(1, n + 1);
		if (n == 0)
			return $urandom_range(0, 17);
		return $urandom_range(1, n);
	endfunction

	function automatic stim_row_t random_row(input bit grow);
		int r;
		int ins_share;
		r = $urandom_range(0, 99);
		ins_share = grow ? 75 : 30;
		if (r < 4)
			return row_of(ACT_SPARE5 + ACTION_W'($urandom_range(0, 2)),
				$urandom_range(0, 31), pick_value());
		if (r < 12)
			return row_of(ACT_DUMP, $urandom_range(0, 31), pick_value());
		if ($urandom_range(0, 99) < ins_share) begin
			case ($urandom_range(0, 2))
			0: return row_of(ACT_INS_HEAD, $urandom_range(0, 31), pick_value());
			1: return row_of(ACT_INS_TAIL, $urandom_range(0, 31), pick_value());
			default: return row_of(ACT_INS_AT, pick_position(1'b1), pick_value());
			endcase
		end
		return row_of(ACT_DEL_AT, pick_position(1'b0), pick_value());
	endfunction

	task automatic drive_item(input stim_row_t row);
		int gap;
		list_beat_t b;
		gap = pick_wait(items_sent);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= row.act;
		position <= row.pos;
		value    <= row.val;
		do @(posedge clk); while (in_stall);
		list_apply(row.act, row.pos, row.val);
		if (row.typed) begin
			b.status = row.t_status;
			b.entry_value = '0;
			b.length = row.t_length;
			b.last = 1'b1;
			due_beats.push_back(b);
		end else begin
			foreach (step_beats[i])
				due_beats.push_back(step_beats[i]);
		end
		items_sent++;
	endtask

	// Receiver: stall a random number of cycles before each beat.
	initial begin : sink
		int n;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			n = pick_wait(beats_taken);
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			beats_taken++;
			got_beat.status = status;
			got_beat.entry_value = entry_value;
			got_beat.length = length;
			got_beat.last = last;
			if (due_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat status=%0d value=%0d len=%0d last=%0b",
					status, entry_value, length, last));
			end else begin
				want_beat = due_beats.pop_front();
				if (got_beat.status !== want_beat.status)
					report_mismatch($sformatf("status got %0d want %0d",
						got_beat.status, want_beat.status));
				if (got_beat.entry_value !== want_beat.entry_value)
					report_mismatch($sformatf("entry_value got %0d want %0d",
						got_beat.entry_value, want_beat.entry_value));
				if (got_beat.length !== want_beat.length)
					report_mismatch($sformatf("length got %0d want %0d",
						got_beat.length, want_beat.length));
				if (got_beat.last !== want_beat.last)
					report_mismatch($sformatf("last got %0b want %0b",
						got_beat.last, want_beat.last));
			end
		end
	end

	initial begin
		int done;
		bit grow;
		stim_row_t r;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		action   = ACT_INS_HEAD;
		position = '0;
		value    = '0;

		dir_rows.push_back('{ACT_DUMP,     5'd0,  32'sd0,         1'b1, STAT_EMPTY,  5'd0});
		dir_rows.push_back('{ACT_DEL_AT,   5'd1,  32'sd0,         1'b1, STAT_BADPOS, 5'd0});
		dir_rows.push_back('{ACT_DEL_AT,   5'd0,  32'sd0,         1'b1, STAT_BADPOS, 5'd0});
		dir_rows.push_back('{ACT_INS_AT,   5'd0,  32'sd5,         1'b1, STAT_BADPOS, 5'd0});
		dir_rows.push_back('{ACT_INS_AT,   5'd2,  32'sd6,         1'b1, STAT_BADPOS, 5'd0});
		dir_rows.push_back('{ACT_INS_TAIL, 5'd0,  32'sh8000_0000, 1'b1, STAT_OK,     5'd1});
		dir_rows.push_back('{ACT_INS_HEAD, 5'd31, 32'sh7FFF_FFFF, 1'b1, STAT_OK,     5'd2});
		dir_rows.push_back('{ACT_INS_AT,   5'd3,  32'sd0,         1'b1, STAT_OK,     5'd3});
		dir_rows.push_back('{ACT_INS_AT,   5'd2,  -32'sd1,        1'b1, STAT_OK,     5'd4});
		dir_rows.push_back('{ACT_INS_AT,   5'd1,  32'sh5A5A_5A5A, 1'b1, STAT_OK,     5'd5});
		dir_rows.push_back(row_of(ACT_DUMP, 0, 32'sd0));
		dir_rows.push_back('{ACT_DEL_AT,   5'd0,  32'sd0,         1'b1, STAT_BADPOS, 5'd5});
		dir_rows.push_back('{ACT_DEL_AT,   5'd6,  32'sd0,         1'b1, STAT_BADPOS, 5'd5});
		dir_rows.push_back('{ACT_DEL_AT,   5'd5,  32'sd0,         1'b1, STAT_OK,     5'd4});
		dir_rows.push_back('{ACT_DEL_AT,   5'd1,  32'sd0,         1'b1, STAT_OK,     5'd3});
		dir_rows.push_back('{ACT_DEL_AT,   5'd2,  32'sd0,         1'b1, STAT_OK,     5'd2});
		dir_rows.push_back(row_of(ACT_SPARE5, 31, -32'sd1));
		dir_rows.push_back(row_of(ACT_SPARE6, 16, 32'sd7));
		dir_rows.push_back(row_of(ACT_SPARE7, 1,  32'sd9));
		dir_rows.push_back('{ACT_INS_TAIL, 5'd0,  32'sd1,         1'b1, STAT_OK,     5'd3});
		dir_rows.push_back(row_of(ACT_DUMP, 0, 32'sd0));
		dir_rows.push_back('{ACT_INS_AT,   5'd17, 32'sd2,         1'b1, STAT_BADPOS, 5'd3});

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			drive_item(dir_rows[i]);

		// Fill to capacity, hit the full-list cases, then delete at the tail and refill it.
		while (shadow_list.size() < CAPACITY) begin
			case ($urandom_range(0, 2))
			0: r = row_of(ACT_INS_HEAD, $urandom_range(0, 31), pick_value());
			1: r = row_of(ACT_INS_TAIL, $urandom_range(0, 31), pick_value());
			default: r = row_of(ACT_INS_AT, $urandom_range(1, shadow_list.size() + 1),
				pick_value());
			endcase
			drive_item(r);
		end
		drive_item(row_of(ACT_INS_HEAD, 0, 32'sd11));
		drive_item(row_of(ACT_INS_TAIL, 0, 32'sd12));
		drive_item(row_of(ACT_INS_AT, 17, 32'sd13));
		drive_item(row_of(ACT_INS_AT, 0, 32'sd14));
		drive_item(row_of(ACT_DUMP, 0, 32'sd0));
		drive_item(row_of(ACT_DEL_AT, 17, 32'sd0));
		drive_item(row_of(ACT_DEL_AT, 16, 32'sd0));
		drive_item(row_of(ACT_INS_AT, 16, pick_value()));
		drive_item(row_of(ACT_DUMP, 0, 32'sd0));

		done = 0;
		grow = 1'b0;
		while (done < RANDOM_ITEMS) begin
			if (shadow_list.size() >= CAPACITY)
				grow = 1'b0;
			else if (shadow_list.size() == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 99) < 3)
				grow = ~grow;
			r = random_row(grow);
			drive_item(r);
			if (r.act <= ACT_DUMP)
				done++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
